[rtl/core/flow_hash_path_selector_core_defines.svh]
// assertion macros for the flow hash path selector core
// used by the top level only
`ifndef FLOW_HASH_PATH_SELECTOR_CORE_DEFINES_SVH
`define FLOW_HASH_PATH_SELECTOR_CORE_DEFINES_SVH
// property that holds at every edge outside reset
`define FHPS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked during reset as well
`define FHPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/core/fhps_pkg.sv]
// types, constants and functions shared by the path selector core
// no dependencies
`timescale 1ns / 1ps
package fhps_pkg;
    localparam int MAX_PATHS = 64;
    localparam int CNT_W = 7;
    localparam int KEY_BYTES = 17;
    localparam int NSTG = KEY_BYTES + 1;
    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;
    localparam logic [15:0] NO_INGRESS = 16'hffff;
    localparam logic [319:0] TKEY = {
        64'h6d5a56da255b0ec2, 64'h4167253d43a38fb0, 64'hd0ca2bcbae7b30b4,
        64'h77cb2da38030f20c, 64'h6a42b73bbeac01fa};

    typedef enum logic [1:0] {
        MODE_CRC = 2'd0, MODE_TOEP = 2'd1, MODE_STRIPE = 2'd2, MODE_BAD = 2'd3
    } t_mode;

    localparam logic REG_HASH_MODE = 1'b0;
    localparam logic REG_NODE_SALT = 1'b1;

    // data carried from cell to cell
    // total needs 8 bits, both sets full gives 128
    typedef struct packed {
        logic          vld;
        logic          no_path;
        logic          use_toep;
        logic [135:0]  key;
        logic [31:0]   crc;
        logic [31:0]   toep;
        logic [6:0]    ns;
        logic [7:0]    total;
    } t_cell;

    // hash-modulo divider stage word
    typedef struct packed {
        logic          vld;
        logic          no_path;
        logic [31:0]   num;
        logic [6:0]    rem;
        logic [6:0]    ns;
        logic [7:0]    total;
    } t_div;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
        end
        return v;
    endfunction

    function automatic logic [31:0] key_window(input int off);
        return TKEY[319 - off -: 32];
    endfunction
endpackage

[rtl/core/fhps_hash_cell.sv]
// one hash cell: folds one key byte into both the crc and toeplitz sums
// depends on fhps_pkg
`timescale 1ns / 1ps
module fhps_hash_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_pos,
    input  fhps_pkg::t_cell i_d,
    output fhps_pkg::t_cell o_d
);
    import fhps_pkg::*;
    t_cell       r_d;
    logic [7:0]  w_byte;
    logic [31:0] w_tx;
    logic [8:0]  w_off;

    assign w_byte = i_d.key[135 - 8 * i_pos -: 8];
    assign w_off  = {1'b0, i_pos, 3'd0};

    always_comb begin
        w_tx = 32'd0;
        for (int k = 0; k < 8; k++) begin
            if (w_byte[7 - k]) begin
                w_tx = w_tx ^ key_window(int'(w_off) + k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= i_d.vld;
        end
        r_d.no_path  <= i_d.no_path;
        r_d.use_toep <= i_d.use_toep;
        r_d.key      <= i_d.key;
        r_d.ns       <= i_d.ns;
        r_d.total    <= i_d.total;
        r_d.crc      <= crc_byte(i_d.crc, w_byte);
        r_d.toep     <= i_d.toep ^ w_tx;
    end
    assign o_d = r_d;
endmodule

[rtl/core/fhps_div_cell.sv]
// one restoring division cell: retires one quotient bit of num mod total
// depends on fhps_pkg
`timescale 1ns / 1ps
module fhps_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fhps_pkg::t_div i_d,
    output fhps_pkg::t_div o_d
);
    import fhps_pkg::*;
    t_div       r_d;
    logic [7:0] w_tr;

    assign w_tr = {i_d.rem, i_d.num[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= i_d.vld;
        end
        r_d.no_path <= i_d.no_path;
        r_d.ns      <= i_d.ns;
        r_d.total   <= i_d.total;
        r_d.num     <= {i_d.num[30:0], 1'b0};
        if (w_tr >= i_d.total) begin
            r_d.rem <= 7'(w_tr - i_d.total);
        end else begin
            r_d.rem <= w_tr[6:0];
        end
    end
    assign o_d = r_d;
endmodule

[rtl/core/flow_hash_path_selector_core.sv]
// top level of the flow hash path selector: config regs, hash and divider cell rows
// depends on fhps_pkg, fhps_hash_cell, fhps_div_cell and the defines header
//
//  channel | direction | handshake         | payload
//  item    | in        | i_start & !o_busy | flow key fields, candidate counts
//  result  | out       | o_done strobe     | path index, set flags
//  config  | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item per cycle; the entry register loads at the accepting edge, then 17 hash
// cells, 32 divider cells and the output register follow, and o_done is driven by
// the output register along with the result fields
// reset is synchronous active low and clears the cell valid bits, o_done and the config registers
// o_busy is always low, the receiver cannot stall, results are never held
`timescale 1ns / 1ps
`include "flow_hash_path_selector_core_defines.svh"
module flow_hash_path_selector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_ingress_port,
    input  logic [6:0]  i_shortest_count,
    input  logic [6:0]  i_other_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [6:0]  o_path_index,
    output logic        o_took_shortest,
    output logic [5:0]  o_set_index,
    output logic        o_no_path
);
    import fhps_pkg::*;

    t_mode       r_mode;
    logic [31:0] r_salt;
    t_cell       w_h [NSTG];
    t_div        w_q [33];
    t_cell       r_in;
    logic [6:0]  w_ns, w_no;
    logic        w_stripe;
    logic [6:0]  w_idx;
    logic        r_done, r_took, r_nop;
    logic [6:0]  r_pidx;
    logic [5:0]  r_sidx;

    assign o_busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CRC;
            r_salt <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HASH_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                REG_NODE_SALT: r_salt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_ns = (i_shortest_count > 7'(MAX_PATHS)) ? 7'(MAX_PATHS) : i_shortest_count;
    assign w_no = (i_other_count > 7'(MAX_PATHS)) ? 7'(MAX_PATHS) : i_other_count;
    assign w_stripe = (r_mode == MODE_STRIPE) && (i_ingress_port != NO_INGRESS);

    // striping puts ingress port in the toep slot and zeroes the key, so it skips the hash at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in.vld <= i_start;
        end
        r_in.no_path  <= (w_ns == 7'd0 && w_no == 7'd0) || (r_mode == MODE_BAD);
        r_in.use_toep <= (r_mode == MODE_TOEP);
        r_in.key      <= {i_src_addr, i_dst_addr, i_src_port, i_dst_port,
                          i_priority_req, r_salt};
        r_in.crc      <= CRC_INIT;
        r_in.toep     <= w_stripe ? {16'd0, i_ingress_port} : 32'd0;
        r_in.ns       <= w_ns;
        r_in.total    <= {1'b0, w_ns} + {1'b0, w_no};
    end

    // stripe marker: toep carries ingress port; reuse use_toep path
    logic r_strp [NSTG];
    always_ff @(posedge i_clk) begin
        r_strp[0] <= w_stripe;
        for (int s = 1; s < NSTG; s++) begin
            r_strp[s] <= r_strp[s - 1];
        end
    end

    assign w_h[0] = r_in;
    for (genvar g = 0; g < KEY_BYTES; g++) begin : g_hash
        t_cell w_ci;
        always_comb begin
            w_ci = w_h[g];
            if (r_strp[g]) begin
                w_ci.key = '0;
            end
        end
        fhps_hash_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (5'(g)),
            .i_d     (w_ci),
            .o_d     (w_h[g + 1])
        );
    end

    always_comb begin
        w_q[0].vld     = w_h[KEY_BYTES].vld;
        w_q[0].no_path = w_h[KEY_BYTES].no_path;
        w_q[0].ns      = w_h[KEY_BYTES].ns;
        w_q[0].total   = w_h[KEY_BYTES].total;
        w_q[0].rem     = 7'd0;
        if (r_strp[KEY_BYTES] || w_h[KEY_BYTES].use_toep) begin
            w_q[0].num = w_h[KEY_BYTES].toep;
        end else begin
            w_q[0].num = ~w_h[KEY_BYTES].crc;
        end
    end

    for (genvar g = 0; g < 32; g++) begin : g_div
        fhps_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_q[g]),
            .o_d     (w_q[g + 1])
        );
    end

    assign w_idx = w_q[32].rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_q[32].vld;
        end
        r_nop <= w_q[32].no_path;
        if (w_q[32].no_path) begin
            r_pidx <= 7'd0;
            r_took <= 1'b0;
            r_sidx <= 6'd0;
        end else if (w_idx < w_q[32].ns) begin
            r_pidx <= w_idx;
            r_took <= 1'b1;
            r_sidx <= w_idx[5:0];
        end else begin
            r_pidx <= w_idx;
            r_took <= 1'b0;
            r_sidx <= 6'(w_idx - w_q[32].ns);
        end
    end

    assign o_done          = r_done;
    assign o_path_index    = r_pidx;
    assign o_took_shortest = r_took;
    assign o_set_index     = r_sidx;
    assign o_no_path       = r_nop;

    `FHPS_ASSERT_CLK(a_nop_zero, i_clk, i_rst_n, (o_done && o_no_path) |-> (o_path_index == 7'd0 && !o_took_shortest), "no_path result with nonzero fields")
    `FHPS_ASSERT_CLK(a_rem_range, i_clk, i_rst_n, (w_q[32].vld && !w_q[32].no_path) |-> (w_q[32].rem < w_q[32].total), "remainder not below total")
    `FHPS_ASSERT_CLK(a_latency, i_clk, i_rst_n, r_in.vld |-> ##50 o_done, "item lost in cell row")
    `FHPS_ASSERT_ALWAYS(a_rst_done, i_clk, !i_rst_n |=> !o_done, "strobe right after reset")
endmodule
